// ===== src/hrht_pkg.sv =====
// Package for the HTTP request header tokenizer.
// Byte codes, field tags, status codes and the result item types.
// No dependencies.
package hrht_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [2:0] TAG_METHOD  = 3'd0;
  localparam logic [2:0] TAG_PATH    = 3'd1;
  localparam logic [2:0] TAG_VERSION = 3'd2;
  localparam logic [2:0] TAG_NAME    = 3'd3;
  localparam logic [2:0] TAG_VALUE   = 3'd4;
  localparam logic [2:0] TAG_NONE    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_COLON = 2'd2;
  localparam logic [1:0] ST_NO_REQ   = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] field_tag;
    logic       line_done;
    logic       header_done;
    logic [1:0] status;
    logic       last_result;
  } res_t;

  // Up to two result items produced by one input item.
  typedef struct packed {
    res_t       r1;
    res_t       r0;
    logic [1:0] cnt;
  } push_t;

endpackage

// ===== src/hrht_if.sv =====
// Channel interfaces for the HTTP request header tokenizer.
// Depends on nothing; widths follow the item fields.
interface hrht_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface hrht_token_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] field_tag;
  logic       line_done;
  logic       header_done;
  logic [1:0] status;
  logic       last_result;

  modport source (output valid, output out_byte, output field_tag, output line_done,
                  output header_done, output status, output last_result, input ready);
  modport sink (input valid, input out_byte, input field_tag, input line_done,
                input header_done, input status, input last_result, output ready);
endinterface

// ===== src/http_request_header_tokenizer.sv =====
// HTTP request header tokenizer. Takes one header byte per cycle on byte_in
// while the result queue has room; emits tagged content bytes, line and header
// ends and status on token_out. Bytes pass an input register, combinational
// decode logic and a four-entry result queue; a new byte is taken every cycle
// while the queue holds two or fewer items, so throughput is one byte per cycle
// whenever token_out keeps up with one item per cycle. A byte yields zero, one
// or two items, read out at the queue head. Depends on hrht_pkg and hrht_if.
module http_request_header_tokenizer (
  input  logic         clk,
  input  logic         rst,
  hrht_byte_if.sink    byte_in,
  hrht_token_if.source token_out
);
  import hrht_pkg::*;

  logic           in_valid;
  logic [7:0]     in_byte;
  logic           in_last;
  logic           advance;
  logic           space;
  push_t          push;
  res_t           head;
  logic [QCW-1:0] count;

  assign space         = count <= QCW'(QDEPTH - 2);
  assign advance       = in_valid && space;
  assign byte_in.ready = !in_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      in_byte <= byte_in.data_byte;
      in_last <= byte_in.is_last;
    end
  end

  hrht_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (in_byte),
    .is_last   (in_last),
    .push      (push)
  );

  hrht_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_en (advance),
    .push    (push),
    .pop     (token_out.ready),
    .head    (head),
    .count   (count)
  );

  assign token_out.valid       = count != '0;
  assign token_out.out_byte    = head.out_byte;
  assign token_out.field_tag   = head.field_tag;
  assign token_out.line_done   = head.line_done;
  assign token_out.header_done = head.header_done;
  assign token_out.status      = head.status;
  assign token_out.last_result = head.last_result;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("result queue overflow");

  a_last_has_result: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |-> push.cnt != 2'd0)
    else $error("last byte produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !space |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("stalled input register changed");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    advance |-> (32'(count) + 32'(push.cnt)) <= 32'(QDEPTH))
    else $error("push exceeds queue space");

endmodule

// ===== src/hrht_core.sv =====
// Tokenizer state and per-byte decode: one input item in, zero to two
// result items out. Depends on hrht_pkg.
module hrht_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          data_byte,
  input  logic                is_last,
  output hrht_pkg::push_t     push
);
  import hrht_pkg::*;

  typedef enum logic [2:0] {
    PH_METHOD, PH_PATH, PH_VERSION, PH_NAME, PH_SKIP, PH_VALUE, PH_HALT
  } phase_t;

  typedef struct packed {
    phase_t     ph;
    logic       emit;
    logic [2:0] tag;
  } step_t;

  phase_t     phase;
  logic       cr_held;
  logic       line_has_content;
  logic [1:0] error_code;

  phase_t     phase_next;
  logic       cr_held_next;
  logic       line_has_content_next;
  logic [1:0] error_code_next;

  res_t       r [2];
  logic [1:0] n;
  logic       ended;
  logic       last_idx;
  step_t      s0;
  step_t      s1;

  function automatic step_t content(input phase_t ph, input logic [7:0] b);
    step_t s;
    s.ph   = ph;
    s.emit = 1'b0;
    s.tag  = TAG_NONE;
    case (ph)
      PH_METHOD: begin
        if (b == CH_SP) s.ph = PH_PATH;
        else begin s.emit = 1'b1; s.tag = TAG_METHOD; end
      end
      PH_PATH: begin
        if (b == CH_SP) s.ph = PH_VERSION;
        else begin s.emit = 1'b1; s.tag = TAG_PATH; end
      end
      PH_VERSION: begin
        s.emit = 1'b1;
        s.tag  = TAG_VERSION;
      end
      PH_NAME: begin
        if (b == CH_COLON) s.ph = PH_SKIP;
        else begin s.emit = 1'b1; s.tag = TAG_NAME; end
      end
      PH_SKIP: begin
        if (b != CH_SP) begin
          s.ph   = PH_VALUE;
          s.emit = 1'b1;
          s.tag  = TAG_VALUE;
        end
      end
      PH_VALUE: begin
        s.emit = 1'b1;
        s.tag  = TAG_VALUE;
      end
      default: ;
    endcase
    return s;
  endfunction

  always_comb begin
    phase_next            = phase;
    cr_held_next          = cr_held;
    line_has_content_next = line_has_content;
    error_code_next       = error_code;
    n                     = 2'd0;
    ended                 = 1'b0;
    s0                    = '0;
    s1                    = '0;
    for (int k = 0; k < 2; k++) begin
      r[k]           = '0;
      r[k].field_tag = TAG_NONE;
    end

    if (phase_next != PH_HALT) begin
      if (cr_held_next) begin
        cr_held_next = 1'b0;
        if (data_byte == CH_LF) begin
          ended = 1'b1;
          if (!line_has_content_next) begin
            if (phase_next <= PH_VERSION) error_code_next = ST_NO_REQ;
            else r[0].header_done = 1'b1;
            phase_next = PH_HALT;
          end else begin
            if (phase_next == PH_METHOD || phase_next == PH_PATH) begin
              error_code_next = ST_NO_SPACE;
              phase_next      = PH_HALT;
            end else if (phase_next == PH_NAME) begin
              error_code_next = ST_NO_COLON;
              phase_next      = PH_HALT;
            end else begin
              phase_next = PH_NAME;
            end
            r[0].line_done = 1'b1;
          end
          n                     = 2'd1;
          line_has_content_next = 1'b0;
        end else begin
          // held CR turns out to be content
          s0                    = content(phase_next, CH_CR);
          line_has_content_next = 1'b1;
          phase_next            = s0.ph;
          if (s0.emit) begin
            r[0].out_byte  = CH_CR;
            r[0].field_tag = s0.tag;
            n              = 2'd1;
          end
        end
      end
      if (!ended) begin
        if (data_byte == CH_CR) begin
          cr_held_next = 1'b1;
        end else begin
          s1                    = content(phase_next, data_byte);
          line_has_content_next = 1'b1;
          phase_next            = s1.ph;
          if (s1.emit) begin
            r[n[0]].out_byte  = data_byte;
            r[n[0]].field_tag = s1.tag;
            n                 = n + 2'd1;
          end
        end
      end
    end

    if (is_last) begin
      if (error_code_next == ST_OK && phase_next <= PH_VERSION) error_code_next = ST_NO_REQ;
      if (n == 2'd0) n = 2'd1;
    end
    last_idx = (n == 2'd2);
    if (is_last) r[last_idx].last_result = 1'b1;
    for (int k = 0; k < 2; k++) r[k].status = error_code_next;

    push.r0  = r[0];
    push.r1  = r[1];
    push.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_METHOD;
      cr_held          <= 1'b0;
      line_has_content <= 1'b0;
      error_code       <= ST_OK;
    end else if (advance) begin
      if (is_last) begin
        phase            <= PH_METHOD;
        cr_held          <= 1'b0;
        line_has_content <= 1'b0;
        error_code       <= ST_OK;
      end else begin
        phase            <= phase_next;
        cr_held          <= cr_held_next;
        line_has_content <= line_has_content_next;
        error_code       <= error_code_next;
      end
    end
  end

endmodule

// ===== src/hrht_queue.sv =====
// Result queue: takes up to two result items per cycle, gives one per cycle while pop is high.
// Depends on hrht_pkg.
module hrht_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_en,
  input  hrht_pkg::push_t        push,
  input  logic                   pop,
  output hrht_pkg::res_t         head,
  output logic [hrht_pkg::QCW-1:0] count
);
  import hrht_pkg::*;

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [1:0]     wr_cnt;
  logic           rd_en;

  assign wr_cnt = push_en ? push.cnt : 2'd0;
  assign rd_en  = pop && (count != '0);
  assign head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem[wr_ptr] <= push.r0;
    if (wr_cnt == 2'd2) mem[wr_ptr + QAW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(wr_cnt);
      rd_ptr <= rd_ptr + QAW'(rd_en);
      count  <= count + QCW'(wr_cnt) - QCW'(rd_en);
    end
  end

endmodule
